>>> design/mts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, constants and the sine table generator for the tuned
// sine oscillator.
// ----------------------------------------------------------------------------
package mts_pkg;

  // default parameter values
  localparam int DEFAULT_SAMPLE_RATE     = 44100;
  localparam int DEFAULT_BLOCK_FRAMES    = 256;
  localparam int DEFAULT_SINE_TABLE_BITS = 10;

  // field widths
  localparam int FREQ_W   = 15;
  localparam int AMP_W    = 15;
  localparam int CTRL_W   = 7;
  localparam int SAMPLE_W = 16;
  localparam int INC_W    = 32;
  localparam int TARGET_W = 16;
  localparam int SINE_W   = 31;
  localparam int IDX_W    = 1;

  // register reset values
  localparam logic [FREQ_W-1:0] RESET_BASE_FREQ = FREQ_W'(220);
  localparam logic [AMP_W-1:0]  RESET_AMPLITUDE = AMP_W'(8000);

  // controller value offsets around the centre value
  localparam logic [TARGET_W:0] CTRL_OFS_HIGH = (TARGET_W + 1)'(128);
  localparam logic [TARGET_W:0] CTRL_OFS_LOW  = (TARGET_W + 1)'(126);

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // q30 constants
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef enum logic {
    REQ_TICK    = 1'b0,
    REQ_CONTROL = 1'b1
  } req_kind_t;

  localparam logic [IDX_W-1:0] REG_BASE_FREQ = 1'b0;
  localparam logic [IDX_W-1:0] REG_AMPLITUDE = 1'b1;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  index;
    logic [FREQ_W-1:0] data;
  } cfg_write_t;

  function automatic longint unsigned sub_floor0(input longint unsigned a,
                                                 input longint unsigned b);
    return (a > b) ? (a - b) : 64'd0;
  endfunction

  // magnitude of sin(pi/2 * x / 2^qbits) in q30, truncating taylor series to x^9
  function automatic longint unsigned sine_mag_q30(input int unsigned x,
                                                   input int unsigned qbits);
    longint unsigned c1, p2, c3, c5, c7, c9, xq, x2, s, y;
    c1 = HALF_PI_Q30;
    p2 = (c1 * c1) >> 30;
    c3 = ((p2 * c1) >> 30) / 6;
    c5 = ((c3 * p2) >> 30) / 20;
    c7 = ((c5 * p2) >> 30) / 42;
    c9 = ((c7 * p2) >> 30) / 72;
    xq = longint'(x) << (30 - qbits);
    x2 = (xq * xq) >> 30;
    s  = sub_floor0(c7, (c9 * x2) >> 30);
    s  = sub_floor0(c5, (s * x2) >> 30);
    s  = sub_floor0(c3, (s * x2) >> 30);
    s  = sub_floor0(c1, (s * x2) >> 30);
    y  = (s * xq) >> 30;
    if (y > ONE_Q30) begin
      y = ONE_Q30;
    end
    return y;
  endfunction

endpackage
`default_nettype wire

>>> design/midi_tuned_sine_oscillator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_tuned_sine_oscillator
// Direct digital synthesis sine source tuned by a MIDI controller value.
// ----------------------------------------------------------------------------
// A sample tick (tuser = 0) yields one signed frame on the master side; a
// controller event (tuser = 1, value in tdata) retunes the oscillator to
// base + 2*(value-64) Hz above the centre or base - 2*(63-value) Hz below
// it, clamped at 0 Hz, and yields nothing. Items of either kind are taken
// one per cycle while tready is high; an event updates the pending tuning in
// the cycle it is taken. Each tick carries the pending frequency through a
// three-stage converter to a 32-bit phase increment (reciprocal multiply and
// remainder fix-up), then the queue, phase add, table read, amplitude
// multiply and output register to its frame. The slave side drops tready
// only while the queue is full and a converted tick waits to enter it. A new
// tuning takes effect only at the first frame of the next block of
// BLOCK_FRAMES frames, and tlast marks the final frame of each block.
// ----------------------------------------------------------------------------
module midi_tuned_sine_oscillator
  import mts_pkg::*;
#(
  parameter int SAMPLE_RATE     = DEFAULT_SAMPLE_RATE,
  parameter int BLOCK_FRAMES    = DEFAULT_BLOCK_FRAMES,
  parameter int SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration writes: 0 = base_frequency, 1 = amplitude
  input  wire logic                cfg_we,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [FREQ_W-1:0]   cfg_data,
  // input items
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [6:0] controller_value, [7] zero
  input  wire logic                s_tuser,   // [0] req_type
  // output frames
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [SAMPLE_W-1:0]      m_tdata,   // [15:0] sample
  output logic                     m_tlast    // block_last
);

  cfg_write_t       cfg;
  logic             q_push;
  logic [INC_W-1:0] q_push_inc;
  logic             q_full;
  logic             q_pop;
  logic [INC_W-1:0] q_pop_inc;
  logic             q_empty;

  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

  // front: takes items, retunes on controller events
  mts_front #(
    .SAMPLE_RATE(SAMPLE_RATE)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_kind (s_tuser),
    .in_value(s_tdata[CTRL_W-1:0]),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_inc   (q_push_inc)
  );

  // ticks wait here with the increment they must use at a block start
  mts_fifo #(
    .WIDTH(INC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_inc),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_inc),
    .empty    (q_empty)
  );

  // back: phase accumulation and sample generation
  mts_back #(
    .BLOCK_FRAMES   (BLOCK_FRAMES),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_inc     (q_pop_inc),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sample(m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire

>>> design/mts_inc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_inc_div
// Three-stage pipeline turning a frequency in hertz into a rounded 32-bit
// phase increment by reciprocal multiplication and a remainder fix-up.
// ----------------------------------------------------------------------------
module mts_inc_div
  import mts_pkg::*;
#(
  parameter int SAMPLE_RATE = DEFAULT_SAMPLE_RATE
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [TARGET_W-1:0] freq,
  output logic                     out_valid,
  output logic [INC_W-1:0]         inc
);

  // 2^32 = REC_Q * rate + REC_R, REC_C is REC_R / rate in 0.32 fixed point
  localparam longint unsigned RATE  = 64'(SAMPLE_RATE);
  localparam longint unsigned REC_Q = (64'd1 << INC_W) / RATE;
  localparam longint unsigned REC_R = (64'd1 << INC_W) - REC_Q * RATE;
  localparam longint unsigned REC_C = (REC_R << INC_W) / RATE;
  localparam longint unsigned HALF  = RATE / 64'd2;

  localparam int LR_W   = $clog2(SAMPLE_RATE);
  localparam int NUM_W  = TARGET_W + LR_W + 1;
  localparam int REM_W  = LR_W + 2;
  localparam int PROD_W = TARGET_W + INC_W;

  logic                s1_valid;
  logic                s2_valid;
  logic [INC_W-1:0]    s1_base;
  logic [INC_W-1:0]    s2_base;
  logic [TARGET_W-1:0] s1_est;
  logic [TARGET_W-1:0] s2_est;
  logic [NUM_W-1:0]    s1_num;
  logic [REM_W-1:0]    s2_rem;
  logic [PROD_W-1:0]   base_prod;
  logic [PROD_W-1:0]   est_prod;
  logic [NUM_W-1:0]    est_back;
  logic [1:0]          fix;

  // f * 2^32 / rate = f * REC_Q + (f * REC_R + rate/2) / rate
  assign base_prod = PROD_W'(freq) * PROD_W'(REC_Q);
  // quotient estimate of the second term, low by at most two
  assign est_prod  = PROD_W'(freq) * PROD_W'(REC_C);
  assign est_back  = NUM_W'(s1_est) * NUM_W'(SAMPLE_RATE);
  // remainder below three times the rate
  assign fix = (s2_rem >= REM_W'(2 * SAMPLE_RATE)) ? 2'd2 :
               (s2_rem >= REM_W'(SAMPLE_RATE))     ? 2'd1 : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_base <= base_prod[INC_W-1:0];
      s1_est  <= est_prod[PROD_W-1 -: TARGET_W];
      s1_num  <= NUM_W'(freq) * NUM_W'(REC_R) + NUM_W'(HALF);
      s2_base <= s1_base;
      s2_est  <= s1_est;
      s2_rem  <= REM_W'(s1_num - est_back);
      inc     <= s2_base + INC_W'(s2_est) + INC_W'(fix);
    end
  end

endmodule
`default_nettype wire

>>> design/mts_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_front
// Accepts items, turns controller events into a pending frequency and
// queues sample ticks tagged with the increment in force at that point.
// ----------------------------------------------------------------------------
module mts_front
  import mts_pkg::*;
#(
  parameter int SAMPLE_RATE = DEFAULT_SAMPLE_RATE
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_write_t        cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_kind,
  input  wire logic [CTRL_W-1:0] in_value,
  input  wire logic              q_full,
  output logic                   q_push,
  output logic [INC_W-1:0]       q_inc
);

  logic [FREQ_W-1:0]   base_freq;
  logic [TARGET_W-1:0] pending_freq;
  logic [TARGET_W:0]   tgt_sum;
  logic [TARGET_W:0]   tgt_ofs;
  logic [TARGET_W-1:0] target;
  logic                base_write;
  logic                accept;
  logic                event_accept;
  logic                tick_accept;
  logic                conv_en;
  logic                conv_valid;

  // target = base + 2*v - 128 (v >= 64) or base + 2*v - 126, clamped at zero
  assign tgt_sum = (TARGET_W + 1)'(base_freq) + (TARGET_W + 1)'({in_value, 1'b0});
  assign tgt_ofs = in_value[CTRL_W-1] ? CTRL_OFS_HIGH : CTRL_OFS_LOW;
  assign target  = (tgt_sum < tgt_ofs) ? '0 : TARGET_W'(tgt_sum - tgt_ofs);

  // converter stalls only when its last stage waits on a full queue
  assign conv_en      = !(conv_valid && q_full);
  assign in_ready     = conv_en;
  assign accept       = in_valid && in_ready;
  assign event_accept = accept && (in_kind == REQ_CONTROL);
  assign tick_accept  = accept && (in_kind == REQ_TICK);
  assign base_write   = cfg.we && (cfg.index == REG_BASE_FREQ);

  assign q_push = conv_valid && !q_full;

  mts_inc_div #(
    .SAMPLE_RATE(SAMPLE_RATE)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (conv_en),
    .in_valid (tick_accept),
    .freq     (pending_freq),
    .out_valid(conv_valid),
    .inc      (q_inc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_freq    <= RESET_BASE_FREQ;
      pending_freq <= TARGET_W'(RESET_BASE_FREQ);
    end else begin
      if (base_write) begin
        base_freq    <= cfg.data;
        pending_freq <= TARGET_W'(cfg.data);
      end else if (event_accept) begin
        pending_freq <= target;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/mts_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_fifo
// Small synchronous queue between the front and the back.
// ----------------------------------------------------------------------------
module mts_fifo
  import mts_pkg::*;
#(
  parameter int WIDTH = INC_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full     = (count == (AW + 1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW + 1)'(push && !full) - (AW + 1)'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

>>> design/mts_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mts_back
// Phase accumulator, quarter-wave sine table, amplitude scaling and the
// output register, as a four-stage pipeline that stalls as one.
// ----------------------------------------------------------------------------
module mts_back
  import mts_pkg::*;
#(
  parameter int BLOCK_FRAMES    = DEFAULT_BLOCK_FRAMES,
  parameter int SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_write_t          cfg,
  input  wire logic                q_empty,
  input  wire logic [INC_W-1:0]    q_inc,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_sample,
  output logic                     out_last
);

  localparam int QB        = SINE_TABLE_BITS - 2;
  localparam int ROM_DEPTH = (1 << QB) + 1;
  localparam int RA_W      = QB + 1;
  localparam int FW        = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
  localparam int PROD_W    = AMP_W + SINE_W;

  logic [SINE_W-1:0] sine_rom [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [SINE_W-1:0] ENTRY = SINE_W'(sine_mag_q30(g, QB));
    assign sine_rom[g] = ENTRY;
  end

  logic [AMP_W-1:0]           amplitude;
  logic [INC_W-1:0]           phase_acc;
  logic [INC_W-1:0]           active_inc;
  logic [INC_W-1:0]           inc_use;
  logic [FW-1:0]              frame;
  logic                       frame_last;
  logic                       adv;

  logic                       s1_valid;
  logic                       s1_last;
  logic [SINE_TABLE_BITS-1:0] s1_idx;
  logic [1:0]                 s1_quad;
  logic [RA_W-1:0]            s1_addr;

  logic                       s2_valid;
  logic                       s2_last;
  logic                       s2_neg;
  logic [SINE_W-1:0]          s2_sine;

  logic                       s3_valid;
  logic                       s3_last;
  logic                       s3_neg;
  logic [PROD_W-1:0]          s3_prod;
  logic [PROD_W-1:0]          s3_round;
  logic [SAMPLE_W-1:0]        s3_mag;

  assign adv        = !out_valid || out_ready;
  assign q_pop      = adv && !q_empty;
  assign frame_last = (frame == FW'(BLOCK_FRAMES - 1));
  assign inc_use    = (frame == '0) ? q_inc : active_inc;

  // table index and quarter-wave mirroring
  assign s1_idx  = phase_acc[INC_W-1 -: SINE_TABLE_BITS];
  assign s1_quad = s1_idx[SINE_TABLE_BITS-1 -: 2];
  assign s1_addr = s1_quad[0] ? (RA_W'(ROM_DEPTH - 1) - RA_W'(s1_idx[QB-1:0]))
                              : RA_W'(s1_idx[QB-1:0]);

  // round half up, then q30 back to integer
  assign s3_round = s3_prod + (PROD_W'(1) << 29);
  assign s3_mag   = s3_round[30 +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude  <= RESET_AMPLITUDE;
      phase_acc  <= '0;
      active_inc <= '0;
      frame      <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.we && (cfg.index == REG_AMPLITUDE)) begin
        amplitude <= cfg.data;
      end
      if (adv) begin
        s1_valid  <= !q_empty;
        s2_valid  <= s1_valid;
        s3_valid  <= s2_valid;
        out_valid <= s3_valid;
        if (!q_empty) begin
          if (frame == '0) begin
            active_inc <= q_inc;
          end
          phase_acc <= phase_acc + inc_use;
          frame     <= frame_last ? '0 : frame + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last    <= frame_last;
      s2_last    <= s1_last;
      s2_neg     <= s1_quad[1];
      s2_sine    <= sine_rom[s1_addr];
      s3_last    <= s2_last;
      s3_neg     <= s2_neg;
      s3_prod    <= PROD_W'(amplitude) * PROD_W'(s2_sine);
      out_last   <= s3_last;
      out_sample <= s3_neg ? (SAMPLE_W'(0) - s3_mag) : s3_mag;
    end
  end

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tuned sine oscillator. A scoreboard class
// tracks the phase accumulator, the pending and active increments and the
// block position. It predicts every frame from the ticks and controller
// events taken on the slave side, and compares each frame on the master
// side. Both sides idle in random bursts, except in the last phase. The run
// steps through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import mts_pkg::*;

  localparam int SR          = DEFAULT_SAMPLE_RATE;
  localparam int BLOCK       = DEFAULT_BLOCK_FRAMES;
  localparam int TABLE_BITS  = DEFAULT_SINE_TABLE_BITS;
  localparam int QB          = TABLE_BITS - 2;
  // settle time covering the converter and frame pipe, with margin
  localparam int SETTLE      = 80;
  localparam int STUCK_LIMIT = 3000;
  localparam int NPHASE      = 8;
  localparam int PHASE_ITEMS = 216;

  // --------------------------------------------------------------------------
  // frame predictor and expected-frame store
  // --------------------------------------------------------------------------
  class tone_scoreboard;
    typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
    } frame_t;

    frame_t            frames_due[$];
    logic [FREQ_W-1:0] base_hz;
    logic [AMP_W-1:0]  amp;
    logic [31:0]       phase;
    logic [31:0]       step_pending;
    logic [31:0]       step_active;
    int unsigned       frame_pos;
    longint unsigned   k1, k2, k3, k5, k7, k9;
    int                errors;
    int                ticks;
    int                events;
    int                frames_ok;
    int                blocks;

    function new();
      // taylor coefficients of sin(pi/2 * x), truncated as the block does
      k1 = HALF_PI_Q30;
      k2 = (k1 * k1) >> 30;
      k3 = ((k2 * k1) >> 30) / 6;
      k5 = ((k3 * k2) >> 30) / 20;
      k7 = ((k5 * k2) >> 30) / 42;
      k9 = ((k7 * k2) >> 30) / 72;
      base_hz      = RESET_BASE_FREQ;
      amp          = RESET_AMPLITUDE;
      phase        = '0;
      step_pending = hz_to_step(longint'(RESET_BASE_FREQ));
      step_active  = '0;
      frame_pos    = 0;
      errors       = 0;
      ticks        = 0;
      events       = 0;
      frames_ok    = 0;
      blocks       = 0;
    endfunction

    // rounded phase step per sample, low 32 bits kept
    function logic [31:0] hz_to_step(longint unsigned hz);
      longint unsigned num;
      num = (hz << 32) + longint'(SR / 2);
      return 32'(num / longint'(SR));
    endfunction

    function longint unsigned clip_sub(longint unsigned a, longint unsigned b);
      return (a > b) ? a - b : 64'd0;
    endfunction

    // q30 magnitude of the sine at the phase; neg set for the lower half
    function longint unsigned unit_sine(input logic [31:0] ph, output bit neg);
      logic [TABLE_BITS-1:0] idx;
      logic [1:0]            quad;
      longint unsigned       frac, x, x2, s, y;
      idx  = ph[31 -: TABLE_BITS];
      quad = idx[TABLE_BITS-1 -: 2];
      frac = longint'(idx[QB-1:0]);
      x    = quad[0] ? ((64'd1 << QB) - frac) : frac;
      x    = x << (30 - QB);
      x2   = (x * x) >> 30;
      s    = clip_sub(k7, (k9 * x2) >> 30);
      s    = clip_sub(k5, (s * x2) >> 30);
      s    = clip_sub(k3, (s * x2) >> 30);
      s    = clip_sub(k1, (s * x2) >> 30);
      y    = (s * x) >> 30;
      if (y > ONE_Q30) begin
        y = ONE_Q30;
      end
      neg = quad[1];
      return y;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [FREQ_W-1:0] val);
      if (idx == REG_BASE_FREQ) begin
        base_hz      = val;
        step_pending = hz_to_step(longint'(val));
      end else if (idx == REG_AMPLITUDE) begin
        amp = AMP_W'(val);
      end
    endfunction

    function void take_request(req_kind_t kind, logic [CTRL_W-1:0] val);
      int              hz;
      bit              neg;
      longint unsigned mag;
      logic [15:0]     m16;
      frame_t          f;
      if (kind == REQ_CONTROL) begin
        events++;
        hz = int'(base_hz);
        if (val >= 64) begin
          hz += (int'(val) - 64) * 2;
        end else begin
          hz -= (63 - int'(val)) * 2;
        end
        if (hz < 0) begin
          hz = 0;
        end
        step_pending = hz_to_step(longint'(hz));
        return;
      end
      ticks++;
      if (frame_pos == 0) begin
        step_active = step_pending;
        blocks++;
      end
      phase = phase + step_active;
      mag = (longint'(amp) * unit_sine(phase, neg) + (64'd1 << 29)) >> 30;
      m16 = mag[15:0];
      f.sample = neg ? (16'd0 - m16) : m16;
      f.last   = (frame_pos >= BLOCK - 1);
      frame_pos = f.last ? 0 : frame_pos + 1;
      frames_due.push_back(f);
    endfunction

    function void check_frame(logic [SAMPLE_W-1:0] smp, logic last);
      frame_t want;
      if (frames_due.size() == 0) begin
        $error("unexpected frame: sample %0d, last %0b", $signed(smp), last);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      if (smp !== want.sample) begin
        $error("sample mismatch: expected %0d, actual %0d",
               $signed(want.sample), $signed(smp));
        errors++;
      end
      if (last !== want.last) begin
        $error("block_last mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
      frames_ok++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut signals and instance
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [FREQ_W-1:0]   cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;   // [6:0] controller_value, [7] zero
  logic                s_tuser;   // [0] req_type
  logic                m_tvalid;
  logic                m_tready;
  logic [SAMPLE_W-1:0] m_tdata;   // [15:0] sample
  logic                m_tlast;   // block_last

  midi_tuned_sine_oscillator uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  tone_scoreboard sb = new();

  bit no_idle     = 1'b0;  // set for the last phase: both sides run flat out
  int stall_left  = 0;
  int stuck_cycles = 0;
  int settings    = 0;

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // monitors: the predictor sees each item in the order the block takes it
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sb.take_request(req_kind_t'(s_tuser), s_tdata[CTRL_W-1:0]);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_frame(m_tdata, m_tlast);
    end
  end

  // receiver: ready drops in random bursts
  always @(posedge clk) begin
    if (rst || no_idle) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog: cycles with no item, frame or register write
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("timeout after %0d cycles without progress", STUCK_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // offer one item, possibly after a random gap; valid stays high between
  // back-to-back items
  task automatic send_item(req_kind_t kind, logic [CTRL_W-1:0] val);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, val};
    do @(posedge clk); while (!s_tready);
  endtask

  // sender pauses until every expected frame is out, then lets the pipe
  // go quiet
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [FREQ_W-1:0] val);
    hold_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    // quiet gap after the write before items resume
    repeat (SETTLE) @(posedge clk);
    settings++;
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, CTRL_W'($urandom_range(0, 127)));
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int base_plan[NPHASE];
    int amp_plan[NPHASE];
    int ph, i, roll, b, a;
    logic [CTRL_W-1:0] edge_vals[4];

    // -1 means a random value in range
    base_plan = '{0, 20000, 20000, -1, 16383, -1, 440, -1};
    amp_plan  = '{32767, 0, 32767, -1, 1, -1, -1, 8000};
    edge_vals = '{7'd0, 7'd63, 7'd64, 7'd127};

    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= REQ_TICK;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset tuning, then controller extremes and the centre pair
    send_item(REQ_TICK, 7'd0);
    send_item(REQ_TICK, 7'd127);
    send_item(REQ_CONTROL, 7'd0);
    send_tick();
    send_item(REQ_CONTROL, 7'd63);
    send_tick();
    send_item(REQ_CONTROL, 7'd64);
    send_tick();
    send_item(REQ_CONTROL, 7'd127);
    send_tick();
    send_item(REQ_CONTROL, 7'd126);
    send_item(REQ_CONTROL, 7'd1);
    send_tick();
    send_tick();

    // zero base: low controller values clamp at 0 Hz; full-scale amplitude
    write_reg(REG_BASE_FREQ, FREQ_W'(0));
    write_reg(REG_AMPLITUDE, FREQ_W'(32767));
    send_item(REQ_CONTROL, 7'd0);
    send_tick();
    send_item(REQ_CONTROL, 7'd127);
    send_tick();
    send_item(REQ_CONTROL, 7'd64);
    send_tick();
    send_tick();
    send_tick();

    // random phases, one base and amplitude setting each; mostly ticks so blocks
    // complete and retunes get latched at block starts
    for (ph = 0; ph < NPHASE; ph++) begin
      b = (base_plan[ph] < 0) ? $urandom_range(0, 20000) : base_plan[ph];
      a = (amp_plan[ph] < 0) ? $urandom_range(0, 32767) : amp_plan[ph];
      if (ph == NPHASE - 1) begin
        no_idle = 1'b1;
      end
      write_reg(REG_BASE_FREQ, FREQ_W'(b));
      write_reg(REG_AMPLITUDE, FREQ_W'(a));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) begin
          hold_until_drained();
        end
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          send_tick();
        end else if (roll < 90) begin
          send_item(REQ_CONTROL, edge_vals[$urandom_range(0, 3)]);
        end else begin
          send_item(REQ_CONTROL, CTRL_W'($urandom_range(0, 127)));
        end
      end
    end

    // drain and let the pipe go quiet
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d ticks and %0d controller events over %0d register writes",
             sb.ticks, sb.events, settings);
    $display("%0d frames compared across %0d blocks, %0d mismatches",
             sb.frames_ok, sb.blocks, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mts_pkg.sv
design/mts_inc_div.sv
design/mts_front.sv
design/mts_fifo.sv
design/mts_back.sv
design/midi_tuned_sine_oscillator.sv
sim/tb.sv
